FILE: hw/rtl/casr_pkg.sv
// Shared constants, id field helpers and byte masks for the audio segment receiver
package casr_pkg;

  localparam int ID_W      = 29;
  localparam int DATA_W    = 64;
  localparam int LEN_W     = 4;
  localparam int ADDR_W    = 7;
  localparam int TIMER_W   = 16;
  localparam int TOTAL_W   = 7;
  localparam int CFG_IDX_W = 2;

  localparam int FRAME_BYTES_DEF = 64;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_GROUP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_POINT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd2;

  // configuration reset values
  localparam logic [ADDR_W-1:0]  OWN_GROUP_RST = 7'd1;
  localparam logic [ADDR_W-1:0]  OWN_POINT_RST = 7'd1;
  localparam logic [TIMER_W-1:0] TIMEOUT_RST   = 16'd500;

  // input item kinds
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // result kinds
  localparam logic OUT_AUDIO   = 1'b0;
  localparam logic OUT_FORWARD = 1'b1;

  // frame types carried in id bits 28:26
  localparam logic [2:0] TYPE_NONE     = 3'd0;
  localparam logic [2:0] TYPE_PC_ALL   = 3'd1;
  localparam logic [2:0] TYPE_PC_GROUP = 3'd2;
  localparam logic [2:0] TYPE_PC_POINT = 3'd3;
  localparam logic [2:0] TYPE_PT_ALL   = 3'd4;

  localparam logic [3:0] CMD_AUDIO = 4'd1;
  localparam logic [LEN_W-1:0] WORD_BYTES = 4'd8;

  function automatic logic [3:0] id_cmd(input logic [ID_W-1:0] id);
    return id[11:8];
  endfunction

  function automatic logic [ADDR_W-1:0] id_group(input logic [ID_W-1:0] id);
    return id[18:12];
  endfunction

  function automatic logic [ADDR_W-1:0] id_point(input logic [ID_W-1:0] id);
    return id[25:19];
  endfunction

  function automatic logic [2:0] id_type(input logic [ID_W-1:0] id);
    return id[28:26];
  endfunction

  // all ones in the lowest nbytes bytes
  function automatic logic [DATA_W-1:0] byte_keep(input logic [LEN_W-1:0] nbytes);
    logic [DATA_W-1:0] keep;
    for (int i = 0; i < 8; i++) begin
      keep[8*i +: 8] = (LEN_W'(i) < nbytes) ? 8'hFF : 8'h00;
    end
    return keep;
  endfunction

endpackage

FILE: hw/rtl/casr_if.sv
// Channel interfaces: received items, results and configuration writes
interface casr_item_if;
  import casr_pkg::*;
  logic              valid;
  logic              ready;
  logic              kind;
  logic              source_bus;
  logic [ID_W-1:0]   frame_id;
  logic [LEN_W-1:0]  frame_len;
  logic [DATA_W-1:0] frame_data;

  modport source (output valid, kind, source_bus, frame_id, frame_len, frame_data,
                  input ready);
  modport sink (input valid, kind, source_bus, frame_id, frame_len, frame_data,
                output ready);
endinterface

interface casr_result_if;
  import casr_pkg::*;
  logic              valid;
  logic              ready;
  logic              out_kind;
  logic              dest_bus;
  logic [ID_W-1:0]   out_id;
  logic [LEN_W-1:0]  out_bytes;
  logic [DATA_W-1:0] out_data;
  logic              last_word;

  modport source (output valid, out_kind, dest_bus, out_id, out_bytes, out_data, last_word,
                  input ready);
  modport sink (input valid, out_kind, dest_bus, out_id, out_bytes, out_data, last_word,
                output ready);
endinterface

interface casr_cfg_if;
  import casr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [TIMER_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/casr_store.sv
// Assembly store: one word per segment, registered read, per-word valid bits
module casr_store #(
  parameter int WORDS = 8,
  parameter int AW    = 3
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [casr_pkg::DATA_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [casr_pkg::DATA_W-1:0] rd_data,
  output logic                      rd_valid
);
  import casr_pkg::*;

  logic [DATA_W-1:0] mem [WORDS];
  logic [WORDS-1:0]  vld;

  // data array, no reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // a word never written since reset reads with rd_valid low
  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= vld[rd_addr];
      end
    end
  end

endmodule

FILE: hw/rtl/can_audio_segment_receiver_unit.sv
// Top level of the audio segment receiver: capture rule, assembly and forwarding
//
//   channel  dir  beat
//   item     in   one received frame or one timer tick
//   result   out  one assembled audio word or one frame forwarded to the other bus
//   cfg      in   one register write (index, data), always ready
//
// A tick passes through accept and evaluate. A frame passes through accept,
// evaluate and forward; a broadcast last segment adds a read-merge-write step
// plus a read and a load per assembled word, as the store has a single read port.
// Reset clears capture, timer and the store's per-word valid bits at once.
// A stalled result holds the block in the emitting state until it is taken.
module can_audio_segment_receiver_unit #(
  parameter int FRAME_BYTES = casr_pkg::FRAME_BYTES_DEF
) (
  input logic           clk,
  input logic           rst,
  casr_item_if.sink     item,
  casr_result_if.source result,
  casr_cfg_if.sink      cfg
);
  import casr_pkg::*;

  localparam int WORDS = (FRAME_BYTES + 7) / 8;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam logic [TOTAL_W-1:0] FRAME_TOTAL = TOTAL_W'(FRAME_BYTES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_MERGE,
    S_READ,
    S_LOAD,
    S_FWD
  } state_t;

  state_t state;

  // configuration
  logic [ADDR_W-1:0]  own_group;
  logic [ADDR_W-1:0]  own_point;
  logic [TIMER_W-1:0] capture_timeout;

  // capture state
  logic [ID_W-1:0]    captured_id;
  logic [TIMER_W-1:0] idle_ticks;

  // latched item
  logic              kind_r;
  logic              bus_r;
  logic [ID_W-1:0]   id_r;
  logic [LEN_W-1:0]  len_r;
  logic [DATA_W-1:0] data_r;

  // emission counters
  logic [TOTAL_W-1:0] rem;
  logic [AW-1:0]      widx;

  // store ports
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [DATA_W-1:0] rd_data;
  logic              rd_valid;

  casr_store #(.WORDS(WORDS), .AW(AW)) u_store (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .rd_valid (rd_valid)
  );

  assign item.ready = (state == S_IDLE);
  assign cfg.ready  = 1'b1;

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      own_group       <= OWN_GROUP_RST;
      own_point       <= OWN_POINT_RST;
      capture_timeout <= TIMEOUT_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_OWN_GROUP: own_group       <= cfg.data[ADDR_W-1:0];
        CFG_OWN_POINT: own_point       <= cfg.data[ADDR_W-1:0];
        CFG_TIMEOUT:   capture_timeout <= cfg.data;
        default: ;
      endcase
    end
  end

  // id fields of the latched frame
  logic [2:0]        typ;
  logic [2:0]        cap_typ;
  logic [3:0]        seg_num;
  logic [3:0]        seg_cnt;
  logic [3:0]        seg_word;
  logic              seg_ok;
  logic              own_addr;
  logic              take;
  logic              audio_ok;
  logic              bcast;

  assign typ      = id_type(id_r);
  assign cap_typ  = id_type(captured_id);
  assign seg_num  = id_r[3:0];
  assign seg_cnt  = id_r[7:4];
  assign seg_word = seg_num - 4'd1;
  assign seg_ok   = ({1'b0, seg_word} < 5'(WORDS));
  assign own_addr = (id_point(id_r) == own_point) && (id_group(id_r) == own_group);
  assign bcast    = (typ == TYPE_PT_ALL) || (typ == TYPE_PC_ALL);

  // source capture priority rule
  always_comb begin
    take = 1'b0;
    case (typ)
      TYPE_PC_ALL:   take = 1'b1;
      TYPE_PC_POINT: take = own_addr;
      TYPE_PC_GROUP: take = (id_group(id_r) == own_group);
      TYPE_PT_ALL: begin
        if (cap_typ == TYPE_NONE) begin
          take = 1'b1;
        end else if (!(cap_typ inside {TYPE_PC_ALL, TYPE_PC_GROUP, TYPE_PC_POINT})) begin
          if (id_group(captured_id) == id_group(id_r) &&
              id_point(captured_id) == id_point(id_r)) begin
            take = 1'b1;
          end else if (id_group(captured_id) != own_group &&
                       id_group(id_r) == own_group) begin
            take = 1'b1;
          end
        end
      end
      default: take = 1'b0;
    endcase
  end

  assign audio_ok = (id_cmd(id_r) == CMD_AUDIO) && take;

  // last segment merge and assembled length
  logic [DATA_W-1:0]  len_keep;
  logic [DATA_W-1:0]  old_word;
  logic [TOTAL_W-1:0] total_raw;
  logic [TOTAL_W-1:0] total;

  assign len_keep  = byte_keep(len_r);
  assign old_word  = rd_valid ? rd_data : '0;
  assign total_raw = TOTAL_W'({seg_word, 3'b000}) + TOTAL_W'(len_r);
  assign total     = (total_raw > FRAME_TOTAL) ? FRAME_TOTAL : total_raw;

  // emitted word size
  logic [LEN_W-1:0] nb;
  logic             last_chunk;

  assign last_chunk = (rem <= TOTAL_W'(WORD_BYTES));
  assign nb         = last_chunk ? rem[LEN_W-1:0] : WORD_BYTES;

  // store access per state
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = seg_word[AW-1:0];
    wr_data = data_r;
    rd_en   = 1'b0;
    rd_addr = widx;
    case (state)
      S_EVAL: begin
        if (kind_r == KIND_FRAME && audio_ok && seg_num != 4'd0) begin
          if (seg_num != seg_cnt) begin
            wr_en = seg_ok;
          end else if (bcast) begin
            rd_en   = 1'b1;
            rd_addr = seg_ok ? seg_word[AW-1:0] : '0;
          end
        end
      end
      S_MERGE: begin
        wr_en   = seg_ok;
        wr_data = (data_r & len_keep) | (old_word & ~len_keep);
      end
      S_READ: begin
        rd_en = 1'b1;
      end
      default: ;
    endcase
  end

  logic               out_free;
  logic               emit_audio;
  logic               emit_fwd;
  logic [TIMER_W-1:0] idle_inc;

  assign out_free   = !result.valid || result.ready;
  assign emit_audio = (state == S_LOAD) && out_free;
  assign emit_fwd   = (state == S_FWD) && !own_addr && out_free;
  assign idle_inc   = (idle_ticks != '1) ? idle_ticks + TIMER_W'(1) : idle_ticks;

  // sequencer, capture state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      captured_id  <= '0;
      idle_ticks   <= '0;
      result.valid <= 1'b0;
    end else begin
      if (emit_audio || emit_fwd) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item.valid) begin
            kind_r <= item.kind;
            bus_r  <= item.source_bus;
            id_r   <= item.frame_id;
            len_r  <= (item.frame_len > WORD_BYTES) ? WORD_BYTES : item.frame_len;
            data_r <= item.frame_data;
            state  <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (kind_r == KIND_TICK) begin
            if (idle_inc >= capture_timeout) begin
              idle_ticks  <= '0;
              captured_id <= '0;
            end else begin
              idle_ticks <= idle_inc;
            end
            state <= S_IDLE;
          end else begin
            if (audio_ok) begin
              captured_id <= id_r;
              idle_ticks  <= '0;
            end
            if (audio_ok && seg_num != 4'd0 && seg_num == seg_cnt && bcast) begin
              state <= S_MERGE;
            end else begin
              state <= S_FWD;
            end
          end
        end
        S_MERGE: begin
          rem   <= total;
          widx  <= '0;
          state <= (total == '0) ? S_FWD : S_READ;
        end
        S_READ: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (out_free) begin
            result.out_kind  <= OUT_AUDIO;
            result.dest_bus  <= 1'b0;
            result.out_id    <= '0;
            result.out_bytes <= nb;
            result.out_data  <= old_word & byte_keep(nb);
            result.last_word <= last_chunk;
            rem              <= rem - TOTAL_W'(WORD_BYTES);
            widx             <= widx + AW'(1);
            state            <= last_chunk ? S_FWD : S_READ;
          end
        end
        S_FWD: begin
          if (own_addr) begin
            state <= S_IDLE;
          end else if (out_free) begin
            result.out_kind  <= OUT_FORWARD;
            result.dest_bus  <= ~bus_r;
            result.out_id    <= id_r;
            result.out_bytes <= len_r;
            result.out_data  <= data_r & len_keep;
            result.last_word <= 1'b0;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
